### hw/rtl/spr_pkg.sv
package spr_pkg;

    localparam int SPR_DUTY_BITS = 15;

    localparam int SPR_ANGLE_W   = 8;
    localparam int SPR_FREQ_W    = 10;
    localparam int SPR_PULSE_W   = 12;
    localparam int SPR_PERIOD_W  = 20;
    localparam int SPR_CFG_IDX_W = 2;
    localparam int SPR_CFG_W     = 10;

    localparam int SPR_PULSE_BASE    = 400;
    localparam int SPR_US_PER_SECOND = 1000000;

    // floor(angle * 2000 / 180) equals (angle * 728200) >> 16 for every 8-bit angle.
    localparam int SPR_RECIP_W     = 20;
    localparam int SPR_ANGLE_RECIP = 728200;
    localparam int SPR_RECIP_SHIFT = 16;

    localparam logic [SPR_ANGLE_W-1:0] SPR_MIN_ANGLE_RST = 8'd0;
    localparam logic [SPR_ANGLE_W-1:0] SPR_MAX_ANGLE_RST = 8'd180;
    localparam logic [SPR_FREQ_W-1:0]  SPR_FREQ_RST      = 10'd50;

    localparam logic [SPR_CFG_IDX_W-1:0] CFG_MIN_ANGLE   = 2'd0;
    localparam logic [SPR_CFG_IDX_W-1:0] CFG_MAX_ANGLE   = 2'd1;
    localparam logic [SPR_CFG_IDX_W-1:0] CFG_PWM_FREQ_HZ = 2'd2;

    localparam logic FUNC_COMMAND = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    typedef struct packed {
        logic capture;
        logic apply_cmd;
        logic start_period;
        logic latch_period;
        logic start_duty;
        logic finish_tick;
        logic load_out;
    } spr_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic ramping;
        logic div_done;
    } spr_stat_t;

endpackage

### hw/rtl/spr_div.sv
module spr_div
    import spr_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 20
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign ge        = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

### hw/rtl/spr_datapath.sv
module spr_datapath
    import spr_pkg::*;
#(
    parameter int DUTY_BITS = SPR_DUTY_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [SPR_CFG_IDX_W-1:0] cfg_index,
    input  logic [SPR_CFG_W-1:0]     cfg_data,
    input  logic                     func,
    input  logic [SPR_ANGLE_W-1:0]   angle,
    input  spr_cmd_t                 cmd,
    output spr_stat_t                stat,
    output logic                     accepted,
    output logic                     moving,
    output logic [SPR_PULSE_W-1:0]   pulse_us,
    output logic [DUTY_BITS-1:0]     duty,
    output logic [SPR_ANGLE_W-1:0]   angle_now
);

    localparam int NUM_W = (SPR_PULSE_W + DUTY_BITS > SPR_PERIOD_W) ?
                           (SPR_PULSE_W + DUTY_BITS) : SPR_PERIOD_W;
    localparam int PROD_W = SPR_ANGLE_W + SPR_RECIP_W;

    localparam logic [SPR_RECIP_W-1:0] ANGLE_RECIP = SPR_RECIP_W'(SPR_ANGLE_RECIP);
    localparam logic [SPR_PULSE_W-1:0] PULSE_BASE  = SPR_PULSE_W'(SPR_PULSE_BASE);
    localparam logic [NUM_W-1:0]       PERIOD_NUM  = NUM_W'(SPR_US_PER_SECOND);
    localparam logic [DUTY_BITS-1:0]   DUTY_MAX    = {DUTY_BITS{1'b1}};

    logic [SPR_ANGLE_W-1:0]  min_reg;
    logic [SPR_ANGLE_W-1:0]  max_reg;
    logic [SPR_FREQ_W-1:0]   freq_reg;

    logic [SPR_PULSE_W-1:0]  position_reg;
    logic [SPR_PULSE_W-1:0]  target_reg;
    logic                    ramping_reg;
    logic [SPR_ANGLE_W-1:0]  committed_reg;
    logic [SPR_PULSE_W-1:0]  pulse_reg;
    logic [DUTY_BITS-1:0]    duty_reg;

    logic                    func_in_reg;
    logic [SPR_ANGLE_W-1:0]  angle_in_reg;
    logic                    accepted_reg;
    logic [SPR_PERIOD_W-1:0] period_reg;

    logic                    accepted_out_reg;
    logic                    moving_out_reg;
    logic [SPR_PULSE_W-1:0]  pulse_out_reg;
    logic [DUTY_BITS-1:0]    duty_out_reg;
    logic [SPR_ANGLE_W-1:0]  angle_out_reg;

    logic [PROD_W-1:0]       scaled;
    logic [SPR_PULSE_W-1:0]  map_us;
    logic                    in_range;
    logic                    take_cmd;
    logic [SPR_PERIOD_W-1:0] freq_eff;
    logic [NUM_W-1:0]        pulse_wide;
    logic [NUM_W-1:0]        duty_numer;
    logic                    div_start;
    logic [NUM_W-1:0]        div_numer;
    logic [SPR_PERIOD_W-1:0] div_denom;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quot;
    logic [DUTY_BITS-1:0]    duty_next;

    assign scaled   = PROD_W'(angle_in_reg) * PROD_W'(ANGLE_RECIP);
    assign map_us   = scaled[SPR_RECIP_SHIFT +: SPR_PULSE_W] + PULSE_BASE;
    assign in_range = (min_reg <= angle_in_reg) && (angle_in_reg <= max_reg);
    assign take_cmd = !ramping_reg && in_range;

    assign freq_eff   = (freq_reg == '0) ? SPR_PERIOD_W'(1) : SPR_PERIOD_W'(freq_reg);
    assign pulse_wide = NUM_W'(position_reg);
    assign duty_numer = (pulse_wide << DUTY_BITS) - pulse_wide;

    assign div_start = cmd.start_period || cmd.start_duty;
    assign div_numer = cmd.start_period ? PERIOD_NUM : duty_numer;
    assign div_denom = cmd.start_period ? freq_eff : period_reg;

    spr_div #(
        .NUM_W (NUM_W),
        .DEN_W (SPR_PERIOD_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        if (position_reg == '0)
        begin
            duty_next = '0;
        end
        else if (SPR_PERIOD_W'(position_reg) > period_reg)
        begin
            duty_next = DUTY_MAX;
        end
        else
        begin
            duty_next = div_quot[DUTY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= SPR_MIN_ANGLE_RST;
            max_reg       <= SPR_MAX_ANGLE_RST;
            freq_reg      <= SPR_FREQ_RST;
            position_reg  <= PULSE_BASE;
            target_reg    <= PULSE_BASE;
            ramping_reg   <= 1'b0;
            committed_reg <= '0;
            pulse_reg     <= '0;
            duty_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_ANGLE:   min_reg  <= cfg_data[SPR_ANGLE_W-1:0];
                    CFG_MAX_ANGLE:   max_reg  <= cfg_data[SPR_ANGLE_W-1:0];
                    CFG_PWM_FREQ_HZ: freq_reg <= cfg_data[SPR_FREQ_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.apply_cmd && take_cmd)
            begin
                target_reg    <= map_us;
                committed_reg <= angle_in_reg;
                ramping_reg   <= 1'b1;
            end
            if (cmd.finish_tick)
            begin
                pulse_reg <= position_reg;
                duty_reg  <= duty_next;
                if (position_reg == target_reg)
                begin
                    ramping_reg <= 1'b0;
                end
                else if (position_reg < target_reg)
                begin
                    position_reg <= position_reg + 1'b1;
                end
                else
                begin
                    position_reg <= position_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_in_reg  <= func;
            angle_in_reg <= angle;
            accepted_reg <= 1'b0;
        end
        else if (cmd.apply_cmd)
        begin
            accepted_reg <= take_cmd;
        end
        if (cmd.latch_period)
        begin
            period_reg <= div_quot[SPR_PERIOD_W-1:0];
        end
        if (cmd.load_out)
        begin
            accepted_out_reg <= accepted_reg;
            moving_out_reg   <= ramping_reg;
            pulse_out_reg    <= pulse_reg;
            duty_out_reg     <= duty_reg;
            angle_out_reg    <= committed_reg;
        end
    end

    assign stat.is_tick  = (func_in_reg == FUNC_TICK);
    assign stat.ramping  = ramping_reg;
    assign stat.div_done = div_done;

    assign accepted  = accepted_out_reg;
    assign moving    = moving_out_reg;
    assign pulse_us  = pulse_out_reg;
    assign duty      = duty_out_reg;
    assign angle_now = angle_out_reg;

endmodule

### hw/rtl/spr_ctrl.sv
module spr_ctrl
    import spr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  spr_stat_t stat,
    output spr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PERIOD,
        ST_DUTY_START,
        ST_DUTY,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.is_tick)
                begin
                    cmd.apply_cmd = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (!stat.ramping)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.start_period = 1'b1;
                    state_next       = ST_PERIOD;
                end
            end
            ST_PERIOD:
            begin
                if (stat.div_done)
                begin
                    cmd.latch_period = 1'b1;
                    state_next       = ST_DUTY_START;
                end
            end
            ST_DUTY_START:
            begin
                cmd.start_duty = 1'b1;
                state_next     = ST_DUTY;
            end
            ST_DUTY:
            begin
                if (stat.div_done)
                begin
                    cmd.finish_tick = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/servo_pulse_ramp.sv
// Servo pulse generator with a slew limit of one microsecond per tick. A command transfer
// (func 0) is taken only when no ramp is running and its angle lies within min_angle and
// max_angle. A tick transfer (func 1) during a ramp drives the current position and steps
// it toward the target, or ends the ramp once it is there; its duty comes from the one
// shared restoring divider, run once for the PWM period and once for the duty, one
// quotient bit per cycle. A tick outside a ramp leaves the position as it is. One item is
// processed at a time, and a finished result waits in an output register while the next
// item is taken.
module servo_pulse_ramp
    import spr_pkg::*;
#(
    parameter int DUTY_BITS = SPR_DUTY_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [SPR_CFG_IDX_W-1:0] cfg_index,
    input  logic [SPR_CFG_W-1:0]     cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic [SPR_ANGLE_W-1:0]   angle,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     accepted,
    output logic                     moving,
    output logic [SPR_PULSE_W-1:0]   pulse_us,
    output logic [DUTY_BITS-1:0]     duty,
    output logic [SPR_ANGLE_W-1:0]   angle_now
);

    spr_cmd_t  cmd;
    spr_stat_t stat;

    spr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spr_datapath #(
        .DUTY_BITS (DUTY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .func      (func),
        .angle     (angle),
        .cmd       (cmd),
        .stat      (stat),
        .accepted  (accepted),
        .moving    (moving),
        .pulse_us  (pulse_us),
        .duty      (duty),
        .angle_now (angle_now)
    );

endmodule

### hw/rtl/spr_checker.sv
module spr_assert
    import spr_pkg::*;
#(
    parameter int DUTY_BITS = SPR_DUTY_BITS
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     accepted,
    input logic                     moving,
    input logic [SPR_PULSE_W-1:0]   pulse_us,
    input logic [DUTY_BITS-1:0]     duty
);

    localparam logic [SPR_PULSE_W-1:0] PULSE_LOW  = SPR_PULSE_W'(SPR_PULSE_BASE);
    localparam logic [SPR_PULSE_W-1:0] PULSE_HIGH = SPR_PULSE_W'(3233);

    // A waiting result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(pulse_us))
        else $error("result changed before its transfer");

    // A taken command always starts a ramp.
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> moving)
        else $error("accepted command without a ramp");

    a_zero_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pulse_us == '0) |-> (duty == '0))
        else $error("zero pulse with nonzero duty");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pulse_us == '0) || ((pulse_us >= PULSE_LOW) && (pulse_us <= PULSE_HIGH)))
        else $error("pulse width outside the servo range");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

endmodule

bind servo_pulse_ramp spr_assert #(.DUTY_BITS(DUTY_BITS)) u_spr_checker (.*);

### bench/spr_checker.sv
module spr_checker
    import spr_pkg::*;
#(
    parameter int DUTY_BITS = SPR_DUTY_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [SPR_CFG_IDX_W-1:0] cfg_index,
    input  logic [SPR_CFG_W-1:0]     cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     func,
    input  logic [SPR_ANGLE_W-1:0]   angle,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic                     accepted,
    input  logic                     moving,
    input  logic [SPR_PULSE_W-1:0]   pulse_us,
    input  logic [DUTY_BITS-1:0]     duty,
    input  logic [SPR_ANGLE_W-1:0]   angle_now,
    output int                       fail_count,
    output int                       outstanding
);

    localparam longint unsigned DUTY_FULL = (64'd1 << DUTY_BITS) - 1;
    localparam int PULSE_SPAN_US  = 2000;
    localparam int ANGLE_SPAN_DEG = 180;

    typedef struct {
        logic                   accepted;
        logic                   moving;
        logic [SPR_PULSE_W-1:0] pulse_us;
        logic [DUTY_BITS-1:0]   duty;
        logic [SPR_ANGLE_W-1:0] angle_now;
    } servo_drive_t;

    logic [SPR_ANGLE_W-1:0] lo_angle;
    logic [SPR_ANGLE_W-1:0] hi_angle;
    logic [SPR_FREQ_W-1:0]  freq_hz;
    logic [SPR_PULSE_W-1:0] position;
    logic [SPR_PULSE_W-1:0] target;
    logic [SPR_PULSE_W-1:0] last_pulse;
    logic [DUTY_BITS-1:0]   last_duty;
    logic [SPR_ANGLE_W-1:0] held_angle;
    logic                   ramp_on;

    servo_drive_t expected_drive[$];
    servo_drive_t oldest;
    int           errors = 0;

    assign fail_count = errors;

    function automatic logic [DUTY_BITS-1:0] duty_for(logic [SPR_PULSE_W-1:0] p);
        longint unsigned hz;
        longint unsigned period;
        hz = freq_hz;
        if (hz == 0)
        begin
            hz = 1;
        end
        period = longint'(SPR_US_PER_SECOND) / hz;
        if (p == '0)
        begin
            return '0;
        end
        if (longint'(p) > period)
        begin
            return DUTY_BITS'(DUTY_FULL);
        end
        return DUTY_BITS'((longint'(p) * DUTY_FULL) / period);
    endfunction

    function automatic servo_drive_t servo_step(logic f, logic [SPR_ANGLE_W-1:0] a);
        servo_drive_t r;
        r.accepted = 1'b0;
        if (f == FUNC_COMMAND)
        begin
            if (!ramp_on && lo_angle <= a && a <= hi_angle)
            begin
                target = SPR_PULSE_W'(int'(a) * PULSE_SPAN_US / ANGLE_SPAN_DEG
                                      + SPR_PULSE_BASE);
                held_angle = a;
                ramp_on = 1'b1;
                r.accepted = 1'b1;
            end
        end
        else if (ramp_on)
        begin
            last_pulse = position;
            last_duty = duty_for(position);
            if (position == target)
            begin
                ramp_on = 1'b0;
            end
            else if (position < target)
            begin
                position = position + 1'b1;
            end
            else
            begin
                position = position - 1'b1;
            end
        end
        r.moving = ramp_on;
        r.pulse_us = last_pulse;
        r.duty = last_duty;
        r.angle_now = held_angle;
        return r;
    endfunction

    task automatic check_field(input string field, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_angle = SPR_MIN_ANGLE_RST;
            hi_angle = SPR_MAX_ANGLE_RST;
            freq_hz = SPR_FREQ_RST;
            position = SPR_PULSE_W'(SPR_PULSE_BASE);
            target = SPR_PULSE_W'(SPR_PULSE_BASE);
            last_pulse = '0;
            last_duty = '0;
            held_angle = '0;
            ramp_on = 1'b0;
            expected_drive.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_ANGLE:   lo_angle = cfg_data[SPR_ANGLE_W-1:0];
                    CFG_MAX_ANGLE:   hi_angle = cfg_data[SPR_ANGLE_W-1:0];
                    CFG_PWM_FREQ_HZ: freq_hz = cfg_data[SPR_FREQ_W-1:0];
                    default:         ;
                endcase
            end
            // A result transfer always belongs to an item taken at an earlier edge.
            if (out_valid && out_ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $error("result transfer with no item outstanding");
                    errors++;
                end
                else
                begin
                    oldest = expected_drive.pop_front();
                    check_field("accepted", oldest.accepted, accepted);
                    check_field("moving", oldest.moving, moving);
                    check_field("pulse_us", oldest.pulse_us, pulse_us);
                    check_field("duty", oldest.duty, duty);
                    check_field("angle_now", oldest.angle_now, angle_now);
                end
            end
            if (in_valid && in_ready)
            begin
                expected_drive.push_back(servo_step(func, angle));
            end
            outstanding <= expected_drive.size();
        end
    end

endmodule

### bench/tb_top.sv
module tb_top;
    import spr_pkg::*;

    localparam logic [SPR_CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int HOLD_CYCLES    = 500;
    localparam int IDLE_PERCENT   = 38;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [SPR_CFG_IDX_W-1:0] cfg_index = '0;
    logic [SPR_CFG_W-1:0]     cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     func = FUNC_COMMAND;
    logic [SPR_ANGLE_W-1:0]   angle = '0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic                     accepted;
    logic                     moving;
    logic [SPR_PULSE_W-1:0]   pulse_us;
    logic [SPR_DUTY_BITS-1:0] duty;
    logic [SPR_ANGLE_W-1:0]   angle_now;
    int                       fail_count;
    int                       outstanding;

    int                     sent_count = 0;
    logic [SPR_ANGLE_W-1:0] lo_angle = SPR_MIN_ANGLE_RST;
    logic [SPR_ANGLE_W-1:0] hi_angle = SPR_MAX_ANGLE_RST;
    int                     cur_angle = 0;
    int                     pos_us = SPR_PULSE_BASE;
    int                     ramp_left = 0;
    logic                   steady;

    assign steady = (sent_count >= 560) && (sent_count < 700);

    servo_pulse_ramp u_top (.*);
    spr_checker u_checker (.*);

    always #4 clk = ~clk;

    task automatic send_item(input logic f, input logic [SPR_ANGLE_W-1:0] a);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        angle <= a;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    task automatic send_cmd(input int a);
        int tgt;
        if (ramp_left == 0 && a >= int'(lo_angle) && a <= int'(hi_angle))
        begin
            tgt = a * 2000 / 180 + SPR_PULSE_BASE;
            ramp_left = ((tgt > pos_us) ? tgt - pos_us : pos_us - tgt) + 1;
            pos_us = tgt;
            cur_angle = a;
        end
        send_item(FUNC_COMMAND, SPR_ANGLE_W'(a));
    endtask

    task automatic send_tick();
        if (ramp_left != 0)
        begin
            ramp_left--;
        end
        send_item(FUNC_TICK, SPR_ANGLE_W'($urandom));
    endtask

    function automatic int walk_angle();
        int a;
        if (lo_angle > hi_angle)
        begin
            return $urandom_range(255);
        end
        a = cur_angle + int'($urandom_range(8)) - 4;
        if (a < int'(lo_angle))
        begin
            a = int'(lo_angle);
        end
        if (a > int'(hi_angle))
        begin
            a = int'(hi_angle);
        end
        return a;
    endfunction

    function automatic int stray_angle();
        if (hi_angle < 8'd255)
        begin
            return $urandom_range(255, int'(hi_angle) + 1);
        end
        if (lo_angle > 8'd0)
        begin
            return $urandom_range(int'(lo_angle) - 1, 0);
        end
        return cur_angle;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_config(input int lo, input int hi, input int hz);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_MIN_ANGLE;
        cfg_data <= {2'($urandom), 8'(lo)};
        @(posedge clk);
        cfg_index <= CFG_MAX_ANGLE;
        cfg_data <= {2'($urandom), 8'(hi)};
        @(posedge clk);
        cfg_index <= CFG_PWM_FREQ_HZ;
        cfg_data <= SPR_CFG_W'(hz);
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data <= SPR_CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        lo_angle = SPR_ANGLE_W'(lo);
        hi_angle = SPR_ANGLE_W'(hi);
    endtask

    // Mostly complete ramps with small steps, mixed with ignored ticks and rejected commands.
    task automatic random_phase(input int n);
        int stop;
        int r;
        stop = sent_count + n;
        while (sent_count < stop)
        begin
            r = $urandom_range(99);
            if (ramp_left != 0)
            begin
                if (r < 85)
                begin
                    send_tick();
                end
                else if (r < 95)
                begin
                    send_cmd($urandom_range(255));
                end
                else
                begin
                    send_cmd(stray_angle());
                end
            end
            else if (r < 65)
            begin
                send_cmd(walk_angle());
            end
            else if (r < 85)
            begin
                send_tick();
            end
            else
            begin
                send_cmd(stray_angle());
            end
        end
    endtask

    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent_count >= 300)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("servo_pulse_ramp test failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick();
        send_cmd(0);
        send_cmd(90);
        send_tick();
        send_tick();
        send_cmd(181);
        send_cmd(255);
        send_cmd(1);
        repeat (6) send_tick();
        set_config(0, 255, 1);
        repeat (6) send_tick();
        set_config(5, 4, 0);
        send_cmd(4);
        send_cmd(5);
        send_tick();

        set_config(0, 180, 50);
        random_phase(100);
        set_config(0, 255, 1023);
        while (ramp_left != 0)
        begin
            send_tick();
        end
        // The climb above a pulse of 977 us reaches duty saturation at 1023 Hz.
        send_cmd(56);
        random_phase(650);
        set_config(20, 200, 1000);
        random_phase(120);
        set_config(0, 255, 0);
        random_phase(60);
        set_config(200, 100, 1);
        random_phase(40);
        set_config(0, 180, 50);
        random_phase(60);

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("servo_pulse_ramp test passed");
        end
        else
        begin
            $display("servo_pulse_ramp test failed");
        end
        $finish;
    end

endmodule
